[rtl/mid_pkg.sv]
`default_nettype none

package mid_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam logic [SAMPLE_W-1:0] FULL = '1;

  localparam int unsigned ACC_W      = 32;
  localparam int unsigned TOT_W      = 40;
  localparam int unsigned CNT_W      = 13;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // shared divider: rounded numerator up to 49 bits, 32-bit divisor
  localparam int unsigned DIV_NUM_W  = 49;
  localparam int unsigned DIV_DEN_W  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_NUM_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_SQUARED        = 3'd0,
    CFG_NOISE_FLOOR        = 3'd1,
    CFG_ALPHA_MODE         = 3'd2,
    CFG_SAMPLES_PER_LINE   = 3'd3,
    CFG_COVERAGE_THRESHOLD = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALPHA_NONE   = 2'd0,
    ALPHA_BOTH   = 2'd1,
    ALPHA_FIRST  = 2'd2,
    ALPHA_SECOND = 2'd3
  } alpha_mode_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LINE,
    B_FRAME,
    B_HOLD
  } back_state_e;

  typedef struct packed {
    logic                use_squared;
    logic [SAMPLE_W-1:0] noise_floor;
    alpha_mode_e         alpha_mode;
    logic [CNT_W-1:0]    samples_per_line;
    logic [TOT_W-1:0]    coverage_threshold;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] accum;
    logic [ACC_W-1:0] weight;
    logic             frame;
  } line_sum_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_resp_t;

endpackage

`default_nettype wire

[rtl/masked_image_difference_metric_core.sv]
// Alpha-weighted mean difference of two sampled images.
// Input channel (in_valid_i/in_ready_o): one pixel pair with its two alphas per item,
// line_end_i and frame_end_i mark the last sample of a line and of the comparison.
// Output channel (out_valid_o/out_ready_i): one item per frame, the mean of the line
// means and the coverage flag; with the flag set the mean reads all ones.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i; the user
// must write only while idle, and the block itself does not enforce it. The front
// pipeline takes one item per cycle unless a line end meets a full line queue. Each
// line end costs the back end a queue pop plus one pass of the shared radix-2
// divider, and a frame end one more pass for the frame mean and the output load.
// Line sums wait in a QUEUE_DEPTH-entry line queue; a full queue holds off the input.
// The frame end item passes the 5 front stages, the queue, two divider passes and
// the output register before its result appears.
// Reset clears all sums, the queue and out_valid_o and loads register defaults.
// A stalled result sits in the output register; the back end keeps working on later
// lines and stops only when the next frame result is ready before that one is taken.
`default_nettype none

module masked_image_difference_metric_core import mid_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   pixel_a_i,
  input  logic [SAMPLE_W-1:0]   pixel_b_i,
  input  logic [SAMPLE_W-1:0]   weight_a_i,
  input  logic [SAMPLE_W-1:0]   weight_b_i,
  input  logic                  line_end_i,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   mean_difference_o,
  output logic                  too_little_overlap_o
);

  cfg_t      cfg_q;
  logic      push;
  line_sum_t push_data;
  logic      full;
  logic      pop;
  line_sum_t pop_data;
  logic      empty;
  div_req_t  div_req;
  div_resp_t div_resp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_squared        <= 1'b0;
      cfg_q.noise_floor        <= '0;
      cfg_q.alpha_mode         <= ALPHA_NONE;
      cfg_q.samples_per_line   <= CNT_W'(1);
      cfg_q.coverage_threshold <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_USE_SQUARED:        cfg_q.use_squared        <= cfg_wdata_i[0];
        CFG_NOISE_FLOOR:        cfg_q.noise_floor        <= cfg_wdata_i[SAMPLE_W-1:0];
        CFG_ALPHA_MODE:         cfg_q.alpha_mode         <= alpha_mode_e'(cfg_wdata_i[1:0]);
        CFG_SAMPLES_PER_LINE:   cfg_q.samples_per_line   <= cfg_wdata_i[CNT_W-1:0];
        CFG_COVERAGE_THRESHOLD: cfg_q.coverage_threshold <= cfg_wdata_i[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  mid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_a_i   (pixel_a_i),
    .pixel_b_i   (pixel_b_i),
    .weight_a_i  (weight_a_i),
    .weight_b_i  (weight_b_i),
    .line_end_i  (line_end_i),
    .frame_end_i (frame_end_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  mid_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .pop_o                (pop),
    .pop_data_i           (pop_data),
    .empty_i              (empty),
    .div_req_o            (div_req),
    .div_resp_i           (div_resp),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .mean_difference_o    (mean_difference_o),
    .too_little_overlap_o (too_little_overlap_o)
  );

endmodule

`default_nettype wire

[rtl/mid_div.sv]
`default_nettype none

module mid_div import mid_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  output div_resp_t resp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] rem_d;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_NUM_W-1:0] quo_d;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] trial;

  // restoring step, one quotient bit per cycle; the numerator shifts out of quo_q
  always_comb begin
    shifted = {rem_q, quo_q[DIV_NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (!trial[DIV_DEN_W+1]) begin
      rem_d = trial[DIV_DEN_W-1:0];
    end else begin
      rem_d = shifted[DIV_DEN_W-1:0];
    end
    quo_d = {quo_q[DIV_NUM_W-2:0], ~trial[DIV_DEN_W+1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= DIV_CNT_W'(DIV_NUM_W - 1);
        if (req_i.den == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= '0;
      // zero divisor gives zero
      quo_q <= (req_i.den == '0) ? '0 : req_i.num;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.quo  = quo_q;

endmodule

`default_nettype wire

[rtl/mid_front.sv]
`default_nettype none

module mid_front import mid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] pixel_a_i,
  input  logic [SAMPLE_W-1:0] pixel_b_i,
  input  logic [SAMPLE_W-1:0] weight_a_i,
  input  logic [SAMPLE_W-1:0] weight_b_i,
  input  logic                line_end_i,
  input  logic                frame_end_i,
  output logic                push_o,
  output line_sum_t           push_data_o,
  input  logic                full_i
);

  // round(x / FULL) for x up to FULL*FULL, no divider:
  // y = q*2^N + lo = q*FULL + (q + lo), with q + lo never above 2*FULL
  function automatic logic [SAMPLE_W-1:0] div_full(input logic [2*SAMPLE_W-1:0] x);
    logic [2*SAMPLE_W:0] y;
    logic [SAMPLE_W:0]   q;
    logic [SAMPLE_W+1:0] r;
    logic [SAMPLE_W:0]   qc;
    y = {1'b0, x} + (2*SAMPLE_W+1)'(FULL >> 1);
    q = y[2*SAMPLE_W:SAMPLE_W];
    r = {1'b0, q} + {2'b00, y[SAMPLE_W-1:0]};
    if (r >= {1'b0, FULL, 1'b0}) begin
      qc = q + (SAMPLE_W+1)'(2);
    end else if (r >= {2'b00, FULL}) begin
      qc = q + (SAMPLE_W+1)'(1);
    end else begin
      qc = q;
    end
    return qc[SAMPLE_W-1:0];
  endfunction

  logic adv;

  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                  le1_q, le2_q, le3_q, le4_q, le5_q;
  logic                  fe1_q, fe2_q, fe3_q, fe4_q, fe5_q;
  logic [SAMPLE_W-1:0]   d1_q, d2_q, ds3_q;
  logic [2*SAMPLE_W-1:0] ww1_q, dd2_q, dw4_q;
  logic [SAMPLE_W-1:0]   wa1_q, wb1_q;
  logic [SAMPLE_W-1:0]   w2_q, w3_q, w4_q, w5_q;
  logic [SAMPLE_W-1:0]   c5_q;

  logic [SAMPLE_W-1:0]   abs_diff;
  logic [SAMPLE_W-1:0]   d1_d;
  logic [SAMPLE_W-1:0]   w2_d;
  logic [SAMPLE_W-1:0]   ds3_d;

  logic [ACC_W-1:0]      line_accum_q, line_accum_d;
  logic [ACC_W-1:0]      line_weight_q, line_weight_d;
  logic [ACC_W:0]        accum_sum;
  logic [ACC_W:0]        weight_sum;
  logic                  eol5;

  assign eol5       = le5_q | fe5_q;
  assign adv        = !(v5_q && eol5 && full_i);
  assign in_ready_o = adv;

  always_comb begin
    abs_diff = (pixel_a_i > pixel_b_i) ? pixel_a_i - pixel_b_i : pixel_b_i - pixel_a_i;
    d1_d     = (abs_diff > cfg_i.noise_floor) ? abs_diff - cfg_i.noise_floor : '0;
  end

  always_comb begin
    case (cfg_i.alpha_mode)
      ALPHA_BOTH:   w2_d = div_full(ww1_q);
      ALPHA_FIRST:  w2_d = wa1_q;
      ALPHA_SECOND: w2_d = wb1_q;
      default:      w2_d = FULL;
    endcase
  end

  assign ds3_d = cfg_i.use_squared ? div_full(dd2_q) : d2_q;

  // line sums saturate at their width
  always_comb begin
    accum_sum     = {1'b0, line_accum_q} + (ACC_W+1)'(c5_q);
    weight_sum    = {1'b0, line_weight_q} + (ACC_W+1)'(w5_q);
    line_accum_d  = accum_sum[ACC_W] ? '1 : accum_sum[ACC_W-1:0];
    line_weight_d = weight_sum[ACC_W] ? '1 : weight_sum[ACC_W-1:0];
  end

  assign push_o            = v5_q && eol5 && !full_i;
  assign push_data_o.accum  = line_accum_d;
  assign push_data_o.weight = line_weight_d;
  assign push_data_o.frame  = fe5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      v5_q          <= 1'b0;
      line_accum_q  <= '0;
      line_weight_q <= '0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (v5_q) begin
        if (eol5) begin
          line_accum_q  <= '0;
          line_weight_q <= '0;
        end else begin
          line_accum_q  <= line_accum_d;
          line_weight_q <= line_weight_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q  <= d1_d;
      ww1_q <= weight_a_i * weight_b_i;
      wa1_q <= weight_a_i;
      wb1_q <= weight_b_i;
      le1_q <= line_end_i;
      fe1_q <= frame_end_i;

      dd2_q <= d1_q * d1_q;
      d2_q  <= d1_q;
      w2_q  <= w2_d;
      le2_q <= le1_q;
      fe2_q <= fe1_q;

      ds3_q <= ds3_d;
      w3_q  <= w2_q;
      le3_q <= le2_q;
      fe3_q <= fe2_q;

      dw4_q <= ds3_q * w3_q;
      w4_q  <= w3_q;
      le4_q <= le3_q;
      fe4_q <= fe3_q;

      c5_q  <= div_full(dw4_q);
      w5_q  <= w4_q;
      le5_q <= le4_q;
      fe5_q <= fe4_q;
    end
  end

endmodule

`default_nettype wire

[rtl/mid_queue.sv]
`default_nettype none

module mid_queue import mid_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_sum_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output line_sum_t pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  line_sum_t         mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [FILL_W-1:0] fill_q;

  assign full_o     = (fill_q == FILL_W'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/mid_back.sv]
`default_nettype none

module mid_back import mid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  output logic                pop_o,
  input  line_sum_t           pop_data_i,
  input  logic                empty_i,
  output div_req_t            div_req_o,
  input  div_resp_t           div_resp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] mean_difference_o,
  output logic                too_little_overlap_o
);

  back_state_e state_q, state_d;

  line_sum_t           ent_q;
  logic [ACC_W-1:0]    frame_accum_q;
  logic [TOT_W-1:0]    total_weight_q;
  logic [CNT_W-1:0]    line_count_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic                low_q;

  logic [DIV_NUM_W-1:0] line_num;
  logic [DIV_DEN_W-1:0] line_den;
  logic [SAMPLE_W-1:0]  quo_sat;
  logic [ACC_W:0]       fa_sum;
  logic [ACC_W-1:0]     frame_accum_d;
  logic [TOT_W-1:0]     tw_add;
  logic [TOT_W:0]       tw_sum;
  logic [TOT_W-1:0]     total_weight_d;
  logic [CNT_W-1:0]     line_count_d;
  logic                 low;
  logic                 load_out;

  // line divider operands from the queue head
  always_comb begin
    if (cfg_i.alpha_mode == ALPHA_NONE) begin
      line_num = DIV_NUM_W'(pop_data_i.accum);
      line_den = DIV_DEN_W'(cfg_i.samples_per_line);
    end else begin
      line_num = DIV_NUM_W'({pop_data_i.accum, {SAMPLE_W{1'b0}}})
               - DIV_NUM_W'(pop_data_i.accum);
      line_den = pop_data_i.weight;
    end
  end

  // quotient clipped to full scale, used for both line and frame means
  assign quo_sat = (|div_resp_i.quo[DIV_NUM_W-1:SAMPLE_W]) ? FULL
                                                          : div_resp_i.quo[SAMPLE_W-1:0];

  always_comb begin
    fa_sum        = {1'b0, frame_accum_q} + (ACC_W+1)'(quo_sat);
    frame_accum_d = fa_sum[ACC_W] ? '1 : fa_sum[ACC_W-1:0];
    if (cfg_i.alpha_mode == ALPHA_NONE) begin
      tw_add = TOT_W'({cfg_i.samples_per_line, {SAMPLE_W{1'b0}}})
             - TOT_W'(cfg_i.samples_per_line);
    end else begin
      tw_add = TOT_W'(ent_q.weight);
    end
    tw_sum         = {1'b0, total_weight_q} + {1'b0, tw_add};
    total_weight_d = tw_sum[TOT_W] ? '1 : tw_sum[TOT_W-1:0];
    line_count_d   = (&line_count_q) ? line_count_q : line_count_q + CNT_W'(1);
  end

  assign low      = total_weight_q < cfg_i.coverage_threshold;
  assign load_out = (state_q == B_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) state_d = B_LINE;
      end
      B_LINE: begin
        if (div_resp_i.done) state_d = ent_q.frame ? B_FRAME : B_IDLE;
      end
      B_FRAME: begin
        if (div_resp_i.done) state_d = B_HOLD;
      end
      B_HOLD: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = line_num + DIV_NUM_W'(line_den >> 1);
    div_req_o.den   = line_den;
    unique case (state_q)
      B_IDLE: begin
        pop_o           = !empty_i;
        div_req_o.start = !empty_i;
      end
      B_LINE: begin
        // frame mean from the sums as they stand after this line
        div_req_o.start = div_resp_i.done && ent_q.frame;
        div_req_o.num   = DIV_NUM_W'(frame_accum_d) + DIV_NUM_W'(line_count_d >> 1);
        div_req_o.den   = DIV_DEN_W'(line_count_d);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      frame_accum_q  <= '0;
      total_weight_q <= '0;
      line_count_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_LINE && div_resp_i.done) begin
        frame_accum_q  <= frame_accum_d;
        total_weight_q <= total_weight_d;
        line_count_q   <= line_count_d;
      end
      if (load_out) begin
        frame_accum_q  <= '0;
        total_weight_q <= '0;
        line_count_q   <= '0;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= pop_data_i;
    end
    if (load_out) begin
      mean_q <= low ? FULL : quo_sat;
      low_q  <= low;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign mean_difference_o    = mean_q;
  assign too_little_overlap_o = low_q;

endmodule

`default_nettype wire

[rtl/mid_checker.sv]
`default_nettype none

module mid_checker import mid_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] mean_difference_o,
  input logic                too_little_overlap_o
);

  // no result is offered while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // low coverage forces the mean to full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_little_overlap_o |-> mean_difference_o == FULL)
    else $error("coverage flag set without full-scale mean");

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_difference_o)
                                    && $stable(too_little_overlap_o))
    else $error("stalled result changed");

endmodule

bind masked_image_difference_metric_core mid_checker u_checker (.*);

`default_nettype wire

[bench/masked_image_difference_metric_core_tb.sv]
`default_nettype none

module masked_image_difference_metric_core_tb;
  import mid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam u64_t FS     = u64_t'(FULL);
  localparam u64_t LIM32  = 64'hFFFF_FFFF;
  localparam u64_t LIM40  = 64'hFF_FFFF_FFFF;
  localparam u64_t LIM13  = 64'h1FFF;
  localparam logic [TOT_W-1:0] THR_MAX = '1;
  localparam int RANDOM_ITEMS = 600;
  localparam int LONG_HOLD    = 1000;
  localparam int SETTLE       = 120;

  typedef struct {
    logic [SAMPLE_W-1:0] pix_a;
    logic [SAMPLE_W-1:0] pix_b;
    logic [SAMPLE_W-1:0] alpha_a;
    logic [SAMPLE_W-1:0] alpha_b;
    logic                eol;
    logic                eof;
  } sample_t;

  typedef struct {
    logic [SAMPLE_W-1:0] mean;
    logic                low;
  } frame_verdict_t;

  typedef struct {
    int             set_no;
    sample_t        smp;
    bit             typed;
    frame_verdict_t want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   pixel_a_i;
  logic [SAMPLE_W-1:0]   pixel_b_i;
  logic [SAMPLE_W-1:0]   weight_a_i;
  logic [SAMPLE_W-1:0]   weight_b_i;
  logic                  line_end_i;
  logic                  frame_end_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SAMPLE_W-1:0]   mean_difference_o;
  logic                  too_little_overlap_o;

  masked_image_difference_metric_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .pixel_a_i           (pixel_a_i),
    .pixel_b_i           (pixel_b_i),
    .weight_a_i          (weight_a_i),
    .weight_b_i          (weight_b_i),
    .line_end_i          (line_end_i),
    .frame_end_i         (frame_end_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .mean_difference_o   (mean_difference_o),
    .too_little_overlap_o(too_little_overlap_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the block's registers and running sums
  cfg_t             shadow;
  logic [ACC_W-1:0] acc_line, wt_line, acc_frame;
  logic [TOT_W-1:0] wt_total;
  logic [CNT_W-1:0] n_lines;

  frame_verdict_t pending_means[$];
  plan_row_t      plan[$];

  int  errors = 0;
  int  n_frames = 0;
  int  n_flagged = 0;
  int  n_sent = 0;
  int  n_settings = 0;
  bit  gappy = 1'b0;
  bit  hold_req = 1'b0;
  int  n_holds = 0;

  function automatic u64_t rdiv(u64_t num, u64_t den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic u64_t sat_sum(u64_t a, u64_t b, u64_t lim);
    u64_t s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic cfg_t mk_cfg(logic sq, logic [SAMPLE_W-1:0] eps, alpha_mode_e m,
                                  logic [CNT_W-1:0] spl, logic [TOT_W-1:0] thr);
    cfg_t c;
    c.use_squared        = sq;
    c.noise_floor        = eps;
    c.alpha_mode         = m;
    c.samples_per_line   = spl;
    c.coverage_threshold = thr;
    return c;
  endfunction

  task automatic clear_sums();
    acc_line  = '0;
    wt_line   = '0;
    acc_frame = '0;
    wt_total  = '0;
    n_lines   = '0;
  endtask

  // folds one accepted item into the sums; got is set when it closes a frame
  task automatic fold_sample(input sample_t s, output bit got, output frame_verdict_t r);
    u64_t pa, pb, d, w, m;
    logic low;
    pa = u64_t'(s.pix_a);
    pb = u64_t'(s.pix_b);
    d  = (pa > pb) ? pa - pb : pb - pa;
    d  = (d > u64_t'(shadow.noise_floor)) ? d - u64_t'(shadow.noise_floor) : 0;
    if (shadow.use_squared) d = rdiv(d * d, FS);
    case (shadow.alpha_mode)
      ALPHA_BOTH:   w = rdiv(u64_t'(s.alpha_a) * u64_t'(s.alpha_b), FS);
      ALPHA_FIRST:  w = u64_t'(s.alpha_a);
      ALPHA_SECOND: w = u64_t'(s.alpha_b);
      default:      w = FS;
    endcase
    acc_line = ACC_W'(sat_sum(u64_t'(acc_line), rdiv(d * w, FS), LIM32));
    wt_line  = ACC_W'(sat_sum(u64_t'(wt_line), w, LIM32));
    if (s.eol || s.eof) begin
      if (shadow.alpha_mode == ALPHA_NONE) begin
        m        = rdiv(u64_t'(acc_line), u64_t'(shadow.samples_per_line));
        wt_total = TOT_W'(sat_sum(u64_t'(wt_total),
                                  u64_t'(shadow.samples_per_line) * FS, LIM40));
      end else begin
        m        = rdiv(u64_t'(acc_line) * FS, u64_t'(wt_line));
        wt_total = TOT_W'(sat_sum(u64_t'(wt_total), u64_t'(wt_line), LIM40));
      end
      if (m > FS) m = FS;
      acc_frame = ACC_W'(sat_sum(u64_t'(acc_frame), m, LIM32));
      n_lines   = CNT_W'(sat_sum(u64_t'(n_lines), 1, LIM13));
      acc_line  = '0;
      wt_line   = '0;
    end
    got = s.eof;
    r   = '{mean: '0, low: 1'b0};
    if (s.eof) begin
      low = (wt_total < shadow.coverage_threshold);
      m   = rdiv(u64_t'(acc_frame), u64_t'(n_lines));
      if (m > FS || low) m = FS;
      r.mean = m[SAMPLE_W-1:0];
      r.low  = low;
      clear_sums();
    end
  endtask

  // offers one item, after a random gap when gappy is set; returns at the falling edge after acceptance
  task automatic send_item(input sample_t s, input bit typed, input frame_verdict_t want);
    int gap, pick;
    bit got;
    frame_verdict_t r;
    gap = 0;
    if (gappy) begin
      pick = $urandom_range(0, 19);
      if (pick >= 19)      gap = $urandom_range(10, 30);
      else if (pick >= 12) gap = $urandom_range(1, 3);
    end
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    pixel_a_i   = s.pix_a;
    pixel_b_i   = s.pix_b;
    weight_a_i  = s.alpha_a;
    weight_b_i  = s.alpha_b;
    line_end_i  = s.eol;
    frame_end_i = s.eof;
    do @(posedge clk_i); while (!in_ready_o);
    fold_sample(s, got, r);
    if (got) begin
      if (typed) r = want;
      pending_means = {pending_means, r};
    end
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
  endtask

  // waits for the block to go quiet, then rewrites every register
  task automatic program_regs(input cfg_t c);
    in_valid_i = 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    write_reg(CFG_USE_SQUARED, CFG_DATA_W'(c.use_squared));
    write_reg(CFG_NOISE_FLOOR, CFG_DATA_W'(c.noise_floor));
    write_reg(CFG_ALPHA_MODE, CFG_DATA_W'(c.alpha_mode));
    write_reg(CFG_SAMPLES_PER_LINE, CFG_DATA_W'(c.samples_per_line));
    write_reg(CFG_COVERAGE_THRESHOLD, CFG_DATA_W'(c.coverage_threshold));
    cfg_we_i = 1'b0;
    shadow   = c;
    n_settings++;
  endtask

  task automatic add_row(input int set_no, input logic [15:0] a, b, wa, wb,
                         input logic le, fe, input bit typed,
                         input logic [15:0] m, input logic f);
    plan_row_t p;
    p.set_no = set_no;
    p.smp    = '{pix_a: a, pix_b: b, alpha_a: wa, alpha_b: wb, eol: le, eof: fe};
    p.typed  = typed;
    p.want   = '{mean: m, low: f};
    plan = {plan, p};
  endtask

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sample_t rand_sample(logic le, logic fe);
    sample_t s;
    int t;
    s.pix_a = rand_level();
    if ($urandom_range(0, 2) == 0) begin
      // close pair, so the noise floor bites
      t = int'(s.pix_a) + $urandom_range(0, 600) - 300;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      s.pix_b = 16'(t);
    end else begin
      s.pix_b = rand_level();
    end
    s.alpha_a = rand_level();
    s.alpha_b = rand_level();
    s.eol     = le;
    s.eof     = fe;
    return s;
  endfunction

  function automatic cfg_t rand_cfg();
    logic [SAMPLE_W-1:0] eps;
    logic [CNT_W-1:0]    spl;
    logic [TOT_W-1:0]    thr;
    case ($urandom_range(0, 3))
      0:       eps = '0;
      1:       eps = 16'($urandom_range(1, 400));
      2:       eps = 16'($urandom_range(0, 65535));
      default: eps = '1;
    endcase
    case ($urandom_range(0, 7))
      0:       spl = 13'd4096;
      1:       spl = 13'd1;
      default: spl = 13'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = THR_MAX;
      2:       thr = {8'($urandom), 32'($urandom)};
      default: thr = TOT_W'($urandom_range(0, 24)) * 40'd65535
                     + TOT_W'($urandom_range(0, 65535));
    endcase
    return mk_cfg(1'($urandom), eps, alpha_mode_e'($urandom_range(0, 3)), spl, thr);
  endfunction

  // result checker
  frame_verdict_t want_now;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result, mean_difference %h too_little_overlap %b",
                 $time, mean_difference_o, too_little_overlap_o);
        errors++;
      end else begin
        want_now = pending_means.pop_front();
        n_frames++;
        if (want_now.low) n_flagged++;
        if (mean_difference_o !== want_now.mean) begin
          $display("%0t: mean_difference expected %h got %h",
                   $time, want_now.mean, mean_difference_o);
          errors++;
        end
        if (too_little_overlap_o !== want_now.low) begin
          $display("%0t: too_little_overlap expected %b got %b",
                   $time, want_now.low, too_little_overlap_o);
          errors++;
        end
      end
    end
  end

  // result side back-pressure; calm and choppy stretches alternate
  initial begin
    int  stall_left;
    int  mode_left;
    bit  choppy;
    stall_left  = 0;
    mode_left   = 100;
    choppy      = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        choppy    = ~choppy;
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (choppy && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d frame results outstanding", pending_means.size());
    $display("** masked_image_difference_metric_core: FAILED **");
    $finish;
  end

  initial begin
    cfg_t      dir_cfg[6];
    plan_row_t p;
    cfg_t      c;
    int        cur_set, n_random, phase, frames, lines, len, dir_items;
    bit        squeeze;
    logic      le, fe;
    frame_verdict_t none;

    none        = '{mean: '0, low: 1'b0};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_USE_SQUARED;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pixel_a_i   = '0;
    pixel_b_i   = '0;
    weight_a_i  = '0;
    weight_b_i  = '0;
    line_end_i  = 1'b0;
    frame_end_i = 1'b0;
    shadow      = mk_cfg(1'b0, '0, ALPHA_NONE, 13'd1, '0);
    clear_sums();

    dir_cfg[0] = shadow;
    dir_cfg[1] = mk_cfg(1'b1, 16'd0, ALPHA_BOTH, 13'd4096, THR_MAX);
    dir_cfg[2] = mk_cfg(1'b0, 16'hFFFF, ALPHA_FIRST, 13'd1, '0);
    dir_cfg[3] = mk_cfg(1'b0, 16'd100, ALPHA_SECOND, 13'd4096, 40'd1000);
    dir_cfg[4] = mk_cfg(1'b1, 16'd0, ALPHA_NONE, 13'd4096, '0);
    dir_cfg[5] = mk_cfg(1'b0, 16'd1, ALPHA_BOTH, 13'd2, 40'd65535);

    // register defaults: single full-scale sample, then a line mean that saturates
    add_row(0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1, 1, 16'hFFFF, 0);
    add_row(0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 16'h0000, 0);
    add_row(0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 1, 16'hFFFF, 0);
    add_row(0, 16'h1234, 16'h1234, 16'hFFFF, 16'h0000, 1, 0, 0, 16'h0000, 0);
    add_row(0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0, 1, 1, 16'h0000, 0);
    // squared, both alphas, threshold out of reach
    add_row(1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1, 0, 0, 16'h0000, 0);
    add_row(1, 16'h8000, 16'h0000, 16'h8000, 16'hFFFF, 0, 1, 1, 16'hFFFF, 1);
    // floor swallows everything; second line has zero weight
    add_row(2, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1, 0, 0, 16'h0000, 0);
    add_row(2, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1, 1, 16'h0000, 0);
    // second alpha, zero weight line inside a frame, then an uncovered frame
    add_row(3, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000, 1, 0, 0, 16'h0000, 0);
    add_row(3, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 0, 0, 0, 16'h0000, 0);
    add_row(3, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 1, 0, 0, 16'h0000, 0);
    add_row(3, 16'h0300, 16'h0000, 16'hFFFF, 16'h7FFF, 0, 1, 0, 16'h0000, 0);
    add_row(3, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0, 1, 1, 16'hFFFF, 1);
    // squared, no alpha, line divisor 4096
    add_row(4, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 16'h0000, 0);
    add_row(4, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1, 0, 0, 16'h0000, 0);
    add_row(4, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 16'h0000, 0);
    // total weight exactly on the threshold, then one weight that rounds to zero
    add_row(5, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1, 1, 1, 16'hFFFE, 0);
    add_row(5, 16'h0001, 16'h0000, 16'h0001, 16'h0001, 0, 1, 1, 16'hFFFF, 1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cur_set = 0;
    gappy   = 1'b1;
    foreach (plan[i]) begin
      p = plan[i];
      if (p.set_no != cur_set) begin
        program_regs(dir_cfg[p.set_no]);
        cur_set = p.set_no;
      end
      send_item(p.smp, p.typed, p.want);
    end
    dir_items = n_sent;

    n_random = 0;
    phase    = 0;
    while (n_random < RANDOM_ITEMS) begin
      phase++;
      c = rand_cfg();
      program_regs(c);
      // one phase with short lines while the result side is held off
      squeeze = (phase == 3);
      gappy   = squeeze ? 1'b0 : 1'($urandom);
      if (squeeze) hold_req = 1'b1;
      frames  = squeeze ? 8 : $urandom_range(2, 5);
      for (int f = 0; f < frames; f++) begin
        lines = squeeze ? 2 : $urandom_range(1, 5);
        for (int l = 0; l < lines; l++) begin
          if (squeeze)                         len = 1;
          else if ($urandom_range(0, 9) == 0)  len = $urandom_range(7, 70);
          else                                 len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            fe = (l == lines - 1) && (k == len - 1);
            le = (k == len - 1);
            if (fe && $urandom_range(0, 2) == 0) le = 1'b0;
            send_item(rand_sample(le, fe), 1'b0, none);
            n_random++;
          end
        end
      end
    end

    in_valid_i = 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("%0d directed and %0d random items over %0d register settings, %0d long hold(s)",
             dir_items, n_random, n_settings, n_holds);
    $display("%0d frame results checked, %0d of them flagged for low coverage",
             n_frames, n_flagged);
    if (errors == 0) begin
      $display("** masked_image_difference_metric_core: PASSED **");
    end else begin
      $display("** masked_image_difference_metric_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/mid_pkg.sv
rtl/mid_div.sv
rtl/mid_front.sv
rtl/mid_queue.sv
rtl/mid_back.sv
rtl/masked_image_difference_metric_core.sv
rtl/mid_checker.sv
bench/masked_image_difference_metric_core_tb.sv
